>>> design/range_second_minimum_query_macros.svh
// assertion macros for the range second-minimum query block
`ifndef RANGE_SECOND_MINIMUM_QUERY_MACROS_SVH
`define RANGE_SECOND_MINIMUM_QUERY_MACROS_SVH
`ifndef SYNTH
`define RSMQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RSMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RSMQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RSMQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/rsmq_pkg.sv
`default_nettype none
package rsmq_pkg;
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_BUILD = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ERROR     = 2'd1;
   localparam logic [1:0] ST_NOT_BUILT = 2'd2;
   localparam int COUNT_WIDTH = 11;
   localparam logic [0:0] REG_ELEMENT_COUNT = 1'd0;
endpackage
`default_nettype wire

>>> design/range_second_minimum_query.sv
`default_nettype none
// Range second-minimum query over a sparse table of minimum positions.
// Input channel req_*: one command per item (load, build, query). Result
// channel rsp_*: exactly one item per input item, status and value.
// Load, unused command and rejected query: the result is registered and
// valid in the cycle after acceptance.
// Build: level 0 is written with identity positions, then each higher
// level is walked entry by entry: two table reads, two value reads, one
// compare and a table write per entry. The value and table memories are
// single-port and are walked by one compare unit.
// Query: two or three range-min lookups (two table reads, two value reads
// each, through the same ports) and a final compare through the same
// unit; the result is registered.
// The block takes one item at a time; req_tready is low from acceptance
// until the result is taken by the receiver.
// A stalled receiver holds the result in the output register.
// Reset (synchronous, active high) clears the built mark and sets
// element_count to 1024; memories are not cleared and must be loaded before
// a build. csr_* is an APB-style port for element_count at address 0.
module range_second_minimum_query #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int VALUE_WIDTH  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] command, [11:2] element_index, [43:12] element_value,
   // [53:44] query_low, [63:54] query_high
   input  wire logic [63:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] second_minimum, [33:32] status, zero fill above
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int LW = $clog2(AW + 1);
   localparam int LEVELS = AW + 1;
   localparam int TW = LW + AW;
   localparam int CW = rsmq_pkg::COUNT_WIDTH;

   typedef enum logic [11:0] {
      S_IDLE = 12'b000000000001, S_BINIT = 12'b000000000010,
      S_BRDA = 12'b000000000100, S_BRDB = 12'b000000001000,
      S_BVA  = 12'b000000010000, S_BVB  = 12'b000000100000,
      S_BWR  = 12'b000001000000, S_QSUB = 12'b000010000000,
      S_QRDA = 12'b000100000000, S_QRDB = 12'b001000000000,
      S_QVA  = 12'b010000000000, S_QDONE = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic built_ff, built_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_val_ff, rsp_val_in;
   logic [1:0] rsp_st_ff, rsp_st_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [AW:0] idx_ff, idx_in;
   logic [AW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [VALUE_WIDTH-1:0] va_ff, va_in;
   // query: sub-query step, range bounds, minimum position, partial best
   logic [2:0] step_ff, step_in;
   logic [AW-1:0] lo_ff, lo_in, hi_ff, hi_in, m_ff, m_in, best_ff, best_in;
   logic best_v_ff, best_v_in;
   logic [AW-1:0] sl_ff, sl_in, sh_ff, sh_in;
   logic [LW-1:0] k_ff, k_in;

   logic v_we, t_we;
   logic [AW-1:0] v_addr;
   logic [VALUE_WIDTH-1:0] v_wd, v_rd;
   logic [TW-1:0] t_addr;
   logic [AW-1:0] t_wd, t_rd;

   rsmq_mem #(.DEPTH(MAX_ELEMENTS), .WIDTH(VALUE_WIDTH)) u_vals (
      .clock(clock), .wr_en(v_we), .addr(v_addr), .wr_data(v_wd), .rd_data(v_rd));
   rsmq_mem #(.DEPTH(LEVELS * (2 ** AW)), .WIDTH(AW)) u_tab (
      .clock(clock), .wr_en(t_we), .addr(t_addr), .wr_data(t_wd), .rd_data(t_rd));

   logic [1:0] cmd;
   logic [9:0] e_idx, q_lo, q_hi;
   logic [31:0] e_val;
   assign cmd = req_tdata[1:0];
   assign e_idx = req_tdata[11:2];
   assign e_val = req_tdata[43:12];
   assign q_lo = req_tdata[53:44];
   assign q_hi = req_tdata[63:54];

   logic [CW-1:0] eff;
   assign eff = (32'(count_ff) > 32'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : count_ff;

   // shared compare unit: signed a <= b
   logic a_le_b;
   assign a_le_b = $signed(va_ff) <= $signed(v_rd);

   logic [AW-1:0] m_new;
   assign m_new = a_le_b ? pa_ff : pb_ff;

   logic [AW:0] half, len;
   logic [LW-1:0] kk;
   assign half = (AW + 1)'(1) << (lvl_ff - LW'(1));
   assign len = {1'b0, sh_ff} - {1'b0, sl_ff} + (AW + 1)'(1);
   always_comb begin
      kk = '0;
      for (int j = 1; j < LEVELS; j++)
         if (len >= ((AW + 1)'(1) << j)) kk = LW'(j);
   end

   logic acc;
   assign acc = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == rsmq_pkg::REG_ELEMENT_COUNT)
                       ? 32'(count_ff) : 32'd0;

   // sub-range that follows the lookup of the current step
   logic nx_v;
   logic [AW-1:0] nx_l, nx_h;
   always_comb begin
      nx_v = 1'b1; nx_l = lo_ff; nx_h = hi_ff;
      unique case (step_ff)
         3'd0: begin
            if (m_new == lo_ff) nx_l = lo_ff + AW'(1);
            else if (m_new == hi_ff) nx_h = hi_ff - AW'(1);
            else nx_h = m_new - AW'(1);
         end
         3'd1: begin
            nx_v = (m_ff != lo_ff) && (m_ff != hi_ff);
            nx_l = m_ff + AW'(1);
         end
         default: nx_v = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; built_in = built_ff;
      rsp_valid_in = rsp_valid_ff; rsp_val_in = rsp_val_ff; rsp_st_in = rsp_st_ff;
      lvl_in = lvl_ff; idx_in = idx_ff; pa_in = pa_ff; pb_in = pb_ff; va_in = va_ff;
      step_in = step_ff; lo_in = lo_ff; hi_in = hi_ff; m_in = m_ff;
      best_in = best_ff; best_v_in = best_v_ff; sl_in = sl_ff; sh_in = sh_ff;
      k_in = k_ff;
      v_we = 1'b0; v_addr = pa_ff; v_wd = '0;
      t_we = 1'b0; t_addr = '0; t_wd = '0;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (csr_psel && csr_penable && csr_pwrite
          && csr_paddr[2] == rsmq_pkg::REG_ELEMENT_COUNT) begin
         count_in = csr_pwdata[CW-1:0];
         built_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               rsp_val_in = '0; rsp_st_in = rsmq_pkg::ST_OK;
               unique case (cmd)
                  rsmq_pkg::CMD_LOAD: begin
                     if (32'(e_idx) < 32'(MAX_ELEMENTS)) begin
                        v_we = 1'b1; v_addr = AW'(e_idx);
                        v_wd = VALUE_WIDTH'($signed(e_val));
                        built_in = 1'b0;
                     end else rsp_st_in = rsmq_pkg::ST_ERROR;
                     rsp_valid_in = 1'b1;
                  end
                  rsmq_pkg::CMD_BUILD: begin
                     lvl_in = '0; idx_in = '0; built_in = 1'b1;
                     state_in = S_BINIT;
                  end
                  rsmq_pkg::CMD_QUERY: begin
                     if (!built_ff) begin
                        rsp_st_in = rsmq_pkg::ST_NOT_BUILT; rsp_valid_in = 1'b1;
                     end else if (q_lo >= q_hi || CW'(q_hi) >= eff) begin
                        rsp_st_in = rsmq_pkg::ST_ERROR; rsp_valid_in = 1'b1;
                     end else begin
                        lo_in = AW'(q_lo); hi_in = AW'(q_hi);
                        sl_in = AW'(q_lo); sh_in = AW'(q_hi);
                        step_in = '0; best_v_in = 1'b0;
                        state_in = S_QSUB;
                     end
                  end
                  default: begin
                     rsp_st_in = rsmq_pkg::ST_ERROR; rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         // level 0: identity positions
         S_BINIT: begin
            if (CW'(idx_ff) < eff) begin
               t_we = 1'b1; t_addr = TW'(idx_ff[AW-1:0]); t_wd = idx_ff[AW-1:0];
               idx_in = idx_ff + (AW + 1)'(1);
            end else begin
               lvl_in = LW'(1); idx_in = '0; state_in = S_BRDA;
            end
         end
         S_BRDA: begin
            if (32'(lvl_ff) >= 32'(LEVELS) || (CW'(half) << 1) > eff) begin
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end else if (CW'(idx_ff) + CW'(half) >= eff) begin
               lvl_in = lvl_ff + LW'(1); idx_in = '0;
            end else begin
               t_addr = {lvl_ff - LW'(1), idx_ff[AW-1:0]};
               state_in = S_BRDB;
            end
         end
         S_BRDB: begin
            pa_in = t_rd;
            t_addr = {lvl_ff - LW'(1), AW'(idx_ff + half)};
            v_addr = t_rd;
            state_in = S_BVA;
         end
         S_BVA: begin
            pb_in = t_rd; va_in = v_rd; v_addr = t_rd; state_in = S_BVB;
         end
         S_BVB: begin
            v_addr = pb_ff; state_in = S_BWR;
         end
         S_BWR: begin
            t_we = 1'b1; t_addr = {lvl_ff, idx_ff[AW-1:0]};
            t_wd = a_le_b ? pa_ff : pb_ff;
            idx_in = idx_ff + (AW + 1)'(1); state_in = S_BRDA;
         end
         // range min of sl..sh
         S_QSUB: begin
            k_in = kk;
            t_addr = {kk, sl_ff};
            state_in = S_QRDA;
         end
         S_QRDA: begin
            pa_in = t_rd; v_addr = t_rd;
            t_addr = {k_ff, AW'(sh_ff + AW'(1) - AW'((AW + 1)'(1) << k_ff))};
            state_in = S_QRDB;
         end
         S_QRDB: begin
            pb_in = t_rd; va_in = v_rd; v_addr = t_rd; state_in = S_QDONE;
         end
         // final compare: best's value is latched, pb's value read next
         S_QVA: begin
            va_in = v_rd; v_addr = pb_ff; state_in = S_QDONE;
         end
         S_QDONE: begin
            // va_ff vs v_rd gives the range minimum; then merge into best
            if (step_ff == 3'd0) begin
               m_in = m_new;
               step_in = 3'd1;
               sl_in = nx_l; sh_in = nx_h; state_in = S_QSUB;
            end else if (step_ff == 3'd1 || step_ff == 3'd2) begin
               if (step_ff == 3'd1 || !best_v_ff) begin
                  best_in = m_new;
                  pb_in = best_in;
               end else begin
                  pb_in = m_new;
               end
               best_v_in = 1'b1;
               step_in = step_ff + 3'd1;
               sl_in = nx_l; sh_in = nx_h;
               if (nx_v && step_ff == 3'd1) state_in = S_QSUB;
               else begin
                  // compare best with candidate pb through the same unit
                  pa_in = best_in; v_addr = best_in; step_in = 3'd3;
                  state_in = S_QVA;
               end
            end else begin
               rsp_val_in = 32'($signed(a_le_b ? va_ff : v_rd));
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= CW'(1024); built_ff <= 1'b0;
         rsp_valid_ff <= 1'b0; step_ff <= '0; best_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; built_ff <= built_in;
         rsp_valid_ff <= rsp_valid_in; step_ff <= step_in; best_v_ff <= best_v_in;
      end
      rsp_val_ff <= rsp_val_in; rsp_st_ff <= rsp_st_in;
      lvl_ff <= lvl_in; idx_ff <= idx_in; pa_ff <= pa_in; pb_ff <= pb_in;
      va_ff <= va_in; lo_ff <= lo_in; hi_ff <= hi_in; m_ff <= m_in;
      best_ff <= best_in; sl_ff <= sl_in; sh_ff <= sh_in; k_ff <= k_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'd0, rsp_st_ff, rsp_val_ff};

   // load and unused commands, answered straight from idle
   logic acc_direct;
   assign acc_direct = acc && cmd != rsmq_pkg::CMD_BUILD && cmd != rsmq_pkg::CMD_QUERY;

`include "range_second_minimum_query_macros.svh"
   `RSMQ_ASSERT_IMPL(a_busy_not_ready, clock, reset, state_ff != S_IDLE, !req_tready)
   `RSMQ_ASSERT_NEXT(a_one_result, clock, reset, acc_direct, rsp_tvalid)
   `RSMQ_ASSERT_IMPL(a_err_zero, clock, reset, rsp_tvalid && rsp_st_ff != rsmq_pkg::ST_OK, rsp_val_ff == 32'd0)
endmodule
`default_nettype wire

>>> design/rsmq_mem.sv
`default_nettype none
// single-port synchronous memory with registered read
module rsmq_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire
